/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ialu_pkg.sv */
package ialu_pkg;

    // Multiplier digit: bits of the multiplier retired per cycle.
    localparam int MUL_DIG = 8;

    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_MUL = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_MOD = 3'd5;
    localparam logic [2:0] OP_POW = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADOP    = 2'd1;
    localparam logic [1:0] ST_DIVZERO  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        MSEL_AB,
        MSEL_ACC_BASE,
        MSEL_BASE_BASE
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        t_msel msel;
        logic  acc_wb;
        logic  base_wb;
        logic  div_start;
        logic  out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       b_zero;
        logic       div_ovf;
        logic       b_pos;
        logic       exp_zero;
        logic       exp_lsb;
        logic       mul_busy;
        logic       div_busy;
    } t_dp_stat;

endpackage

/* design/ialu_if.sv */
interface ialu_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input cmd, input operand_a, input operand_b,
                  output ready);
endinterface

interface ialu_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic        [1:0]  status;

    modport source (output valid, output result, output status, input ready);
    modport sink (input valid, input result, input status, output ready);
endinterface

/* design/integer_alu_div_mod_pow.sv */
// Integer ALU: add, subtract, multiply, truncating divide, remainder and power on
// signed operands, computed at DATA_WIDTH bits and wrapped. One request word gives
// one response word. Add, subtract and an unknown opcode go from decode straight
// to the result; multiply runs on the shared multiplier that retires 8 multiplier
// bits per cycle; divide and modulo run on the one-bit-per-cycle restoring
// divider, which divide by zero and the overflow case skip. Power runs
// square-and-multiply on the same multiplier; exponent zero or negative skips it.
// One request is in flight at a time; the next is accepted the cycle after the
// response is loaded, even while that response still waits to be taken.
module integer_alu_div_mod_pow #(
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ialu_req_if.sink         i_req,
    ialu_rsp_if.source       o_rsp
);
    import ialu_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    ialu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ialu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (i_req.cmd),
        .i_operand_a (i_req.operand_a),
        .i_operand_b (i_req.operand_b),
        .o_result    (o_rsp.result),
        .o_status    (o_rsp.status)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule

/* design/ialu_dp.sv */
module ialu_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ialu_pkg::t_dp_cmd  i_cmd,
    output ialu_pkg::t_dp_stat o_stat,
    input  logic        [2:0]  i_op,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic signed [31:0] o_result,
    output logic        [1:0]  o_status
);
    import ialu_pkg::*;

    localparam int W         = DATA_WIDTH;
    localparam int MUL_STEPS = (W + MUL_DIG - 1) / MUL_DIG;
    localparam int MCW       = $clog2(MUL_STEPS + 1);
    localparam int DCW       = $clog2(W + 1);
    localparam logic [W-1:0] MIN_VAL = W'(1) << (W - 1);

    logic [2:0]   r_op;
    logic [W-1:0] r_a, r_b;
    logic [W-1:0] r_acc, r_base, r_exp;
    logic [W-1:0] r_mx, r_my, r_mp;
    logic [MCW-1:0] r_mcnt;
    logic [W-1:0] r_dq, r_dr, r_dd;
    logic [DCW-1:0] r_dcnt;
    logic signed [31:0] r_result;
    logic [1:0]   r_status;

    logic signed [63:0] a_ext, b_ext;
    logic [W-1:0] a_w, b_w;
    logic a_neg, b_neg, b_zero, div_ovf;
    logic [W-1:0] a_mag, b_mag;
    logic [W-1:0] mx_sel, my_sel;
    logic [W+MUL_DIG-1:0] pp;
    logic [W:0]   div_t, div_sub;
    logic         div_ge;
    logic [W-1:0] n_res_w;
    logic signed [W-1:0] n_res_s;
    logic signed [63:0] n_res_64;
    logic [1:0]   n_status;

    // Operands are sign-extended, then cut to the datapath width.
    assign a_ext = 64'(i_operand_a);
    assign b_ext = 64'(i_operand_b);
    assign a_w   = a_ext[W-1:0];
    assign b_w   = b_ext[W-1:0];

    assign a_neg   = r_a[W-1];
    assign b_neg   = r_b[W-1];
    assign b_zero  = (r_b == '0);
    assign div_ovf = (r_a == MIN_VAL) && (&r_b);
    assign a_mag   = a_neg ? (~r_a + 1'b1) : r_a;
    assign b_mag   = b_neg ? (~r_b + 1'b1) : r_b;

    always_comb begin
        case (i_cmd.msel)
            MSEL_AB: begin
                mx_sel = r_a;
                my_sel = r_b;
            end
            MSEL_ACC_BASE: begin
                mx_sel = r_acc;
                my_sel = r_base;
            end
            MSEL_BASE_BASE: begin
                mx_sel = r_base;
                my_sel = r_base;
            end
            default: begin
                mx_sel = r_a;
                my_sel = r_b;
            end
        endcase
    end

    // One multiplier digit per cycle; only the low W bits of the product are kept.
    assign pp = (W + MUL_DIG)'(r_mx) * (W + MUL_DIG)'(r_my[MUL_DIG-1:0]);

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign div_t   = {r_dr, r_dq[W-1]};
    assign div_ge  = (div_t >= {1'b0, r_dd});
    assign div_sub = div_t - {1'b0, r_dd};

    always_comb begin
        n_res_w  = '0;
        n_status = ST_OK;
        case (r_op)
            OP_ADD: n_res_w = r_a + r_b;
            OP_SUB: n_res_w = r_a - r_b;
            OP_MUL: n_res_w = r_mp;
            OP_DIV: begin
                if (b_zero) begin
                    n_status = ST_DIVZERO;
                end else if (div_ovf) begin
                    n_status = ST_OVERFLOW;
                    n_res_w  = r_a;
                end else begin
                    n_res_w = (a_neg ^ b_neg) ? (~r_dq + 1'b1) : r_dq;
                end
            end
            OP_MOD: begin
                if (b_zero) begin
                    n_status = ST_DIVZERO;
                end else if (div_ovf) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_res_w = a_neg ? (~r_dr + 1'b1) : r_dr;
                end
            end
            OP_POW: n_res_w = r_acc;
            default: n_status = ST_BADOP;
        endcase
    end

    assign n_res_s  = n_res_w;
    assign n_res_64 = 64'(n_res_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op   <= i_op;
                r_a    <= a_w;
                r_b    <= b_w;
                r_acc  <= W'(1);
                r_base <= a_w;
                r_exp  <= b_w;
            end
            if (i_cmd.mul_start) begin
                r_mx   <= mx_sel;
                r_my   <= my_sel;
                r_mp   <= '0;
                r_mcnt <= MCW'(MUL_STEPS);
            end else if (r_mcnt != '0) begin
                r_mp   <= r_mp + pp[W-1:0];
                r_mx   <= r_mx << MUL_DIG;
                r_my   <= r_my >> MUL_DIG;
                r_mcnt <= r_mcnt - 1'b1;
            end
            if (i_cmd.acc_wb) begin
                r_acc <= r_mp;
            end
            if (i_cmd.base_wb) begin
                r_base <= r_mp;
                r_exp  <= r_exp >> 1;
            end
            if (i_cmd.div_start) begin
                r_dq   <= a_mag;
                r_dr   <= '0;
                r_dd   <= b_mag;
                r_dcnt <= DCW'(W);
            end else if (r_dcnt != '0) begin
                r_dr   <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
                r_dq   <= {r_dq[W-2:0], div_ge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_result <= n_res_64[31:0];
                r_status <= n_status;
            end
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.b_zero   = b_zero;
    assign o_stat.div_ovf  = div_ovf;
    assign o_stat.b_pos    = !b_neg && !b_zero;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.mul_busy = (r_mcnt != '0);
    assign o_stat.div_busy = (r_dcnt != '0);

    assign o_result = r_result;
    assign o_status = r_status;

endmodule

/* design/ialu_ctrl.sv */
`include "assert_macros.svh"

module ialu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ialu_pkg::t_dp_stat i_stat,
    output ialu_pkg::t_dp_cmd  o_cmd
);
    import ialu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_PCHK,
        S_PMUL,
        S_PSQ,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_MUL: begin
                        cmd.mul_start = 1'b1;
                        cmd.msel      = MSEL_AB;
                        n_state       = S_MUL;
                    end
                    OP_DIV, OP_MOD: begin
                        if (i_stat.b_zero || i_stat.div_ovf) begin
                            n_state = S_FIN;
                        end else begin
                            cmd.div_start = 1'b1;
                            n_state       = S_DIV;
                        end
                    end
                    OP_POW: n_state = i_stat.b_pos ? S_PCHK : S_FIN;
                    default: n_state = S_FIN;
                endcase
            end
            S_MUL: begin
                if (!i_stat.mul_busy) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_FIN;
                end
            end
            S_PCHK: begin
                if (i_stat.exp_zero) begin
                    n_state = S_FIN;
                end else if (i_stat.exp_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.msel      = MSEL_ACC_BASE;
                    n_state       = S_PMUL;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.msel      = MSEL_BASE_BASE;
                    n_state       = S_PSQ;
                end
            end
            S_PMUL: begin
                // The accumulator takes the product while the squaring starts.
                if (!i_stat.mul_busy) begin
                    cmd.acc_wb    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.msel      = MSEL_BASE_BASE;
                    n_state       = S_PSQ;
                end
            end
            S_PSQ: begin
                if (!i_stat.mul_busy) begin
                    cmd.base_wb = 1'b1;
                    n_state     = S_PCHK;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_in_ready = (n_state == S_IDLE);
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ASSERT_ALWAYS(a_units_exclusive, i_clk, i_rst_n, !(i_stat.mul_busy && i_stat.div_busy), "multiplier and divider busy together")
    `ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, i_in_valid && r_in_ready, r_state == S_DECODE, "accepted word not decoded")
    `ASSERT_IMPLY(a_fin_units_idle, i_clk, i_rst_n, r_state == S_FIN, !i_stat.mul_busy && !i_stat.div_busy, "result taken while a unit runs")
    `ASSERT_IMPLY(a_ready_only_idle, i_clk, i_rst_n, r_in_ready, r_state == S_IDLE && !i_stat.mul_busy && !i_stat.div_busy, "ready outside idle")

endmodule
